>>> rtl/haptic_pattern_sequencer_assert.svh
// Assertion macros for the haptic pattern sequencer.
`ifndef HAPTIC_PATTERN_SEQUENCER_ASSERT_SVH
`define HAPTIC_PATTERN_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
`define HPS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("hps: invariant violated");
`define HPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hps: next-cycle check failed");
`else
`define HPS_ASSERT_ALWAYS(lbl, expr)
`define HPS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/hps_pkg.sv
`timescale 1ns / 1ps

package hps_pkg;

  localparam int QUEUE_SLOTS  = 4;
  localparam int MAX_MS       = 2000;
  localparam int EFFECT_COUNT = 5;
  localparam int ROM_EFFECTS  = 5;
  localparam int LEVEL_TOP    = 127;
  localparam int LEVEL_ROUND  = 50;
  localparam int PCT_MAX      = 100;

  // divide by 100 as multiply by reciprocal, exact for values below 2^14
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;

  localparam int MS_W    = $clog2(MAX_MS + 1);
  localparam int TIME_W  = (MS_W > 8) ? MS_W : 8;
  localparam int FILL_W  = $clog2(QUEUE_SLOTS + 1);
  localparam int IDX_W   = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int LEVEL_W = 7;
  localparam int PCT_W   = 7;

  typedef enum logic [1:0] {
    FN_TICK = 2'd0,
    FN_PLAY = 2'd1,
    FN_BUZZ = 2'd2,
    FN_STOP = 2'd3
  } func_t;

  typedef struct packed {
    logic               raw;
    logic [2:0]         effect;
    logic [MS_W-1:0]    ms;
    logic [LEVEL_W-1:0] level;
  } req_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } qctl_t;

  typedef struct packed {
    logic [TIME_W-1:0]  on;
    logic [TIME_W-1:0]  off;
    logic [LEVEL_W-1:0] level;
    logic [1:0]         rep;
    logic [1:0]         count;
  } pulse_t;

  function automatic logic [LEVEL_W-1:0] level_of(input logic [PCT_W-1:0] pct);
    logic [13:0] x;
    logic [26:0] p;
    x = 14'({7'd0, pct} * 14'(LEVEL_TOP)) + 14'(LEVEL_ROUND);
    p = {13'd0, x} * 27'(DIV100_MUL);
    return p[DIV100_SHIFT +: LEVEL_W];
  endfunction

  function automatic logic [TIME_W-1:0] clamp_on(input logic [TIME_W-1:0] on);
    logic [TIME_W-1:0] t;
    t = (on > TIME_W'(MAX_MS)) ? TIME_W'(MAX_MS) : on;
    if (t == '0) begin
      t = TIME_W'(1);
    end
    return t;
  endfunction

  function automatic pulse_t pulse_get(input req_t r, input logic [1:0] pidx);
    pulse_t     p;
    logic [2:0] e;
    logic [2:0] first;
    logic [2:0] k;
    p = '0;
    e = 3'd0;
    first = 3'd0;
    k = 3'd0;
    if (r.raw) begin
      p.on    = TIME_W'(r.ms);
      p.off   = '0;
      p.level = r.level;
      p.rep   = 2'd1;
      p.count = 2'd1;
    end else begin
      case (r.effect)
        3'd5:    e = 3'd0;
        3'd6:    e = 3'd1;
        3'd7:    e = 3'd2;
        default: e = r.effect;
      endcase
      case (e)
        3'd0:    first = 3'd0;
        3'd1:    first = 3'd1;
        3'd2:    first = 3'd2;
        3'd3:    first = 3'd4;
        default: first = 3'd5;
      endcase
      k = first + {2'd0, pidx[0]};
      if (k > 3'd5) begin
        k = 3'd5;
      end
      case (k)
        3'd0: begin
          p.on = TIME_W'(20);  p.off = TIME_W'(0);   p.level = level_of(7'd40);
          p.rep = 2'd1;
        end
        3'd1: begin
          p.on = TIME_W'(25);  p.off = TIME_W'(0);   p.level = level_of(7'd75);
          p.rep = 2'd1;
        end
        3'd2: begin
          p.on = TIME_W'(30);  p.off = TIME_W'(60);  p.level = level_of(7'd70);
          p.rep = 2'd1;
        end
        3'd3: begin
          p.on = TIME_W'(70);  p.off = TIME_W'(0);   p.level = level_of(7'd100);
          p.rep = 2'd1;
        end
        3'd4: begin
          p.on = TIME_W'(90);  p.off = TIME_W'(110); p.level = level_of(7'd100);
          p.rep = 2'd3;
        end
        default: begin
          p.on = TIME_W'(220); p.off = TIME_W'(180); p.level = level_of(7'd100);
          p.rep = 2'd2;
        end
      endcase
      p.count = (e == 3'd2) ? 2'd2 : 2'd1;
    end
    return p;
  endfunction

endpackage

>>> rtl/hps_queue.sv
`timescale 1ns / 1ps

module hps_queue import hps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  qctl_t             ctl,
  input  req_t              wr_req,
  output req_t              rd_req,
  output logic [FILL_W-1:0] fill,
  output logic [FILL_W-1:0] fill_next
);

  req_t             slots [QUEUE_SLOTS];
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] head_next;
  logic [IDX_W:0]   tail_sum;
  logic [IDX_W-1:0] tail;

  assign tail_sum = {1'b0, head} + (IDX_W + 1)'(fill);
  assign tail = (tail_sum >= (IDX_W + 1)'(QUEUE_SLOTS))
              ? IDX_W'(tail_sum - (IDX_W + 1)'(QUEUE_SLOTS))
              : tail_sum[IDX_W-1:0];

  assign rd_req = slots[head];

  always_comb begin
    head_next = head;
    if (ctl.pop) begin
      head_next = (head == IDX_W'(QUEUE_SLOTS - 1)) ? '0 : head + IDX_W'(1);
    end
    if (ctl.flush) begin
      fill_next = '0;
    end else if (ctl.push) begin
      fill_next = fill + FILL_W'(1);
    end else if (ctl.pop) begin
      fill_next = fill - FILL_W'(1);
    end else begin
      fill_next = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      slots[tail] <= wr_req;
    end
  end

endmodule

>>> rtl/haptic_pattern_sequencer.sv
`timescale 1ns / 1ps
// Haptic pattern sequencer.
// Input stream: one request per transfer. s_axis_tuser selects the kind:
// tick (one millisecond of playback), play a named effect, raw buzz, stop.
// Play and buzz requests wait in a four-deep queue and are dropped when it
// is full; each tick starts the oldest request when nothing is playing and
// then plays one millisecond of it.
// Output stream: exactly one result per input request, carrying accepted,
// the motor drive (on flag and 7-bit level), playing, finished and the
// queue fill after the request.
// The result is registered: a request accepted at one edge has its result on
// m_axis_tdata right after that edge.
// Throughput is one request per cycle while the receiver takes results, set
// by the single pass from the state registers to the result register.
// A stalled receiver holds the result register; a new request is taken in
// the same cycle the held result is taken, so the block only stalls while
// the result register is full and not being drained.
// Reset clears the queue, ends playback and empties the output register.
module haptic_pattern_sequencer import hps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] effect_index, [18:3] duration_ms, [26:19] strength_pct, [31:27] zero
  input  logic [31:0] s_axis_tdata,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] accepted, [1] drive_on, [8:2] drive_level, [9] playing,
  // [10] finished, [13:11] queued_count, [15:14] zero
  output logic [15:0] m_axis_tdata
);

  `include "haptic_pattern_sequencer_assert.svh"

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  func_t       func;
  logic [2:0]  effect_index;
  logic [15:0] duration_ms;
  logic [7:0]  strength_pct;
  logic        in_fire;

  logic              busy, busy_next;
  req_t              cur_req, cur_req_next;
  logic [1:0]        pulse_index, pulse_index_next;
  logic [1:0]        repeat_index, repeat_index_next;
  phase_t            phase, phase_next;
  logic [TIME_W-1:0] phase_remaining, phase_remaining_next;

  logic [15:0] out_data_next;

  qctl_t             q_ctl;
  req_t              q_wr;
  req_t              q_head;
  logic [FILL_W-1:0] q_fill;
  logic [FILL_W-1:0] q_fill_next;

  logic              start;
  req_t              cur0;
  logic [1:0]        pidx0, ridx0;
  phase_t            ph0;
  logic              busy0;
  pulse_t            info0, info1;
  logic [TIME_W-1:0] rem0, rem1;
  logic              more_rep, more_pulse;
  logic              q_full;
  logic [MS_W-1:0]   ms_c;
  logic [PCT_W-1:0]  pct_c;

  logic              accepted, drive_on, finished;
  logic [LEVEL_W-1:0] drive_level;

  assign func         = func_t'(s_axis_tuser);
  assign effect_index = s_axis_tdata[2:0];
  assign duration_ms  = s_axis_tdata[18:3];
  assign strength_pct = s_axis_tdata[26:19];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  hps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctl       (q_ctl),
    .wr_req    (q_wr),
    .rd_req    (q_head),
    .fill      (q_fill),
    .fill_next (q_fill_next)
  );

  assign q_full = (q_fill >= FILL_W'(QUEUE_SLOTS));
  assign ms_c   = (duration_ms > 16'(MAX_MS)) ? MS_W'(MAX_MS) : duration_ms[MS_W-1:0];
  assign pct_c  = (strength_pct > 8'(PCT_MAX)) ? PCT_W'(PCT_MAX) : strength_pct[PCT_W-1:0];

  assign start = (func == FN_TICK) && !busy && (q_fill != '0);
  assign cur0  = start ? q_head : cur_req;
  assign pidx0 = start ? 2'd0 : pulse_index;
  assign ridx0 = start ? 2'd0 : repeat_index;
  assign ph0   = start ? PH_ON : phase;
  assign busy0 = busy || start;
  assign info0 = pulse_get(cur0, pidx0);
  assign info1 = pulse_get(cur0, pidx0 + 2'd1);
  assign rem0  = start ? clamp_on(info0.on) : phase_remaining;
  assign rem1  = (rem0 != '0) ? rem0 - TIME_W'(1) : '0;
  assign more_rep   = ({1'b0, ridx0} + 3'd1) < {1'b0, info0.rep};
  assign more_pulse = ({1'b0, pidx0} + 3'd1) < {1'b0, info0.count};

  always_comb begin
    busy_next            = busy;
    cur_req_next         = cur_req;
    pulse_index_next     = pulse_index;
    repeat_index_next    = repeat_index;
    phase_next           = phase;
    phase_remaining_next = phase_remaining;
    q_ctl       = '0;
    q_wr        = '0;
    accepted    = 1'b0;
    finished    = 1'b0;
    drive_on    = 1'b0;
    drive_level = '0;
    case (func)
      FN_TICK: begin
        q_ctl.pop         = start;
        busy_next         = busy0;
        cur_req_next      = cur0;
        pulse_index_next  = pidx0;
        repeat_index_next = ridx0;
        phase_next        = ph0;
        if (busy0) begin
          if (ph0 == PH_ON) begin
            drive_on    = 1'b1;
            drive_level = info0.level;
          end
          phase_remaining_next = rem1;
          if (rem1 == '0) begin
            if (ph0 == PH_ON && (more_rep || more_pulse) && info0.off != '0) begin
              phase_next           = PH_GAP;
              phase_remaining_next = info0.off;
            end else if (more_rep) begin
              repeat_index_next    = ridx0 + 2'd1;
              phase_next           = PH_ON;
              phase_remaining_next = clamp_on(info0.on);
            end else if (more_pulse) begin
              pulse_index_next     = pidx0 + 2'd1;
              repeat_index_next    = 2'd0;
              phase_next           = PH_ON;
              phase_remaining_next = clamp_on(info1.on);
            end else begin
              busy_next            = 1'b0;
              phase_next           = PH_IDLE;
              phase_remaining_next = '0;
              finished             = 1'b1;
            end
          end
        end
      end
      FN_PLAY: begin
        q_wr.raw    = 1'b0;
        q_wr.effect = effect_index;
        if ({1'b0, effect_index} < 4'(EFFECT_COUNT) &&
            {1'b0, effect_index} < 4'(ROM_EFFECTS) && !q_full) begin
          q_ctl.push = 1'b1;
          accepted   = 1'b1;
        end
      end
      FN_BUZZ: begin
        q_wr.raw   = 1'b1;
        q_wr.ms    = ms_c;
        q_wr.level = level_of(pct_c);
        if (ms_c != '0 && !q_full) begin
          q_ctl.push = 1'b1;
          accepted   = 1'b1;
        end
      end
      FN_STOP: begin
        q_ctl.flush          = 1'b1;
        finished             = busy;
        busy_next            = 1'b0;
        phase_next           = PH_IDLE;
        phase_remaining_next = '0;
      end
      default: begin
      end
    endcase
    if (func != FN_TICK && busy_next && phase_next == PH_ON) begin
      drive_on    = 1'b1;
      drive_level = info0.level;
    end
    if (!in_fire) begin
      q_ctl = '0;
    end
  end

  assign out_data_next = {2'b00, 3'(q_fill_next), finished, busy_next, drive_level,
                          drive_on, accepted};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      cur_req         <= '0;
      pulse_index     <= 2'd0;
      repeat_index    <= 2'd0;
      phase           <= PH_IDLE;
      phase_remaining <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (in_fire) begin
        busy            <= busy_next;
        cur_req         <= cur_req_next;
        pulse_index     <= pulse_index_next;
        repeat_index    <= repeat_index_next;
        phase           <= phase_next;
        phase_remaining <= phase_remaining_next;
        m_axis_tvalid   <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= out_data_next;
    end
  end

  `HPS_ASSERT_ALWAYS(a_fill_bound, q_fill <= FILL_W'(QUEUE_SLOTS))
  `HPS_ASSERT_ALWAYS(a_busy_phase, busy == (phase != PH_IDLE))
  `HPS_ASSERT_ALWAYS(a_busy_time_left, !busy || phase_remaining != '0)
  `HPS_ASSERT_NEXT(a_stop_flushes, in_fire && func == FN_STOP, q_fill == '0 && !busy)

endmodule
